[hdl/hcic_pkg.sv]
package hcic_pkg;

  // Direction codes carried by the cmd field
  localparam logic CMD_XY_TO_D = 1'b0;
  localparam logic CMD_D_TO_XY = 1'b1;

  // Configuration register
  localparam int          CFG_W            = 5;
  localparam logic [4:0]  GRID_ORDER_RESET = 5'd8;

  // Fixed field widths
  localparam int COORD_W = 16;
  localparam int DIST_W  = 32;

  // Control that travels with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic cmd;
  } hcic_ctrl_t;

endpackage

[hdl/hcic_level.sv]
module hcic_level #(
  parameter int N  = 16,
  parameter int K  = 0,
  parameter int OW = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  hcic_pkg::hcic_ctrl_t ctrl_in,
  input  logic [OW-1:0]       order_in,
  input  logic [N-1:0]        x_in,
  input  logic [N-1:0]        y_in,
  input  logic [2*N-1:0]      d_in,
  output hcic_pkg::hcic_ctrl_t ctrl_out,
  output logic [OW-1:0]       order_out,
  output logic [N-1:0]        x_out,
  output logic [N-1:0]        y_out,
  output logic [2*N-1:0]      d_out
);
  import hcic_pkg::*;

  // Coordinates to distance walk levels from the top, distance to coordinates from the bottom
  localparam int XY_LVL = N - 1 - K;
  localparam int DX_LVL = K;
  localparam logic [N-1:0] LOW_MASK = {N{1'b1}} >> (N - DX_LVL);

  logic           xy_rx;
  logic           xy_ry;
  logic           dx_rx;
  logic           dx_ry;
  logic [N-1:0]   x_next;
  logic [N-1:0]   y_next;
  logic [2*N-1:0] d_next;

  // Quadrant bits for this level
  assign xy_rx = x_in[XY_LVL];
  assign xy_ry = y_in[XY_LVL];
  assign dx_rx = d_in[2*DX_LVL+1];
  assign dx_ry = d_in[2*DX_LVL] ^ d_in[2*DX_LVL+1];

  // Apply one level of rotation or reflection
  always_comb begin
    x_next = x_in;
    y_next = y_in;
    d_next = d_in;
    unique case (ctrl_in.cmd)
      CMD_XY_TO_D: begin
        if (order_in > XY_LVL) begin
          d_next[2*XY_LVL +: 2] = {xy_rx, xy_rx ^ xy_ry};
          if (!xy_ry) begin
            if (xy_rx) begin
              x_next = ~y_in;
              y_next = ~x_in;
            end else begin
              x_next = y_in;
              y_next = x_in;
            end
          end
        end
      end
      CMD_D_TO_XY: begin
        if (order_in > DX_LVL) begin
          if (!dx_ry) begin
            if (dx_rx) begin
              x_next = ~y_in & LOW_MASK;
              y_next = ~x_in & LOW_MASK;
            end else begin
              x_next = y_in;
              y_next = x_in;
            end
          end
          x_next[DX_LVL] = dx_rx;
          y_next[DX_LVL] = dx_ry;
        end
      end
      default: begin
        x_next = x_in;
      end
    endcase
  end

  // Advance the valid bit and hold the payload for the next level
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    ctrl_out.cmd <= ctrl_in.cmd;
    order_out    <= order_in;
    x_out        <= x_next;
    y_out        <= y_next;
    d_out        <= d_next;
  end

endmodule

[hdl/hilbert_curve_index_converter.sv]
// Channel   Signals                          Transfer
// -------   ------------------------------   ------------------------------
// config    cfg_we, cfg_wdata                edge with cfg_we high
// input     start, busy, cmd, x_in, y_in,    edge with start high, busy low
//           d_in
// result    done, d_out, x_out, y_out        edge that ends the done cycle
//
// One item enters per cycle; the result passes through the input register that
// captures at the transfer edge, one pipeline stage per curve level and an
// output stage that sets done.
// Reset clears every valid bit and loads grid_order with 8.
// The receiver cannot stall, so busy stays low and the pipeline never holds.
module hilbert_curve_index_converter #(
  parameter int MAX_ORDER = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hcic_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd,
  input  logic [hcic_pkg::COORD_W-1:0]      x_in,
  input  logic [hcic_pkg::COORD_W-1:0]      y_in,
  input  logic [hcic_pkg::DIST_W-1:0]       d_in,
  output logic                              done,
  output logic [hcic_pkg::DIST_W-1:0]       d_out,
  output logic [hcic_pkg::COORD_W-1:0]      x_out,
  output logic [hcic_pkg::COORD_W-1:0]      y_out
);
  import hcic_pkg::*;

  localparam int N  = MAX_ORDER;
  localparam int DW = 2 * MAX_ORDER;
  localparam int OW = $clog2(MAX_ORDER + 1);

  logic [CFG_W-1:0] grid_order;
  logic [OW-1:0]    eff_order;

  hcic_ctrl_t       ctrl_s  [0:N];
  logic [OW-1:0]    order_s [0:N];
  logic [N-1:0]     x_s     [0:N];
  logic [N-1:0]     y_s     [0:N];
  logic [DW-1:0]    d_s     [0:N];

  // Nothing ever holds the pipeline
  assign busy = 1'b0;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_order <= GRID_ORDER_RESET;
    end else if (cfg_we) begin
      grid_order <= cfg_wdata;
    end
  end

  // Saturate the order at the pipeline depth
  always_comb begin
    if (grid_order > MAX_ORDER) begin
      eff_order = OW'(MAX_ORDER);
    end else begin
      eff_order = OW'(grid_order);
    end
  end

  // Input stage: capture the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_s[0].valid <= 1'b0;
    end else begin
      ctrl_s[0].valid <= start && !busy;
    end
    ctrl_s[0].cmd <= cmd;
    order_s[0]    <= eff_order;
    if (cmd == CMD_D_TO_XY) begin
      x_s[0] <= '0;
      y_s[0] <= '0;
      d_s[0] <= DW'(d_in);
    end else begin
      x_s[0] <= N'(x_in);
      y_s[0] <= N'(y_in);
      d_s[0] <= '0;
    end
  end

  // One stage per curve level
  for (genvar k = 0; k < N; k++) begin : g_level
    hcic_level #(
      .N  (N),
      .K  (k),
      .OW (OW)
    ) u_level (
      .clk       (clk),
      .rst       (rst),
      .ctrl_in   (ctrl_s[k]),
      .order_in  (order_s[k]),
      .x_in      (x_s[k]),
      .y_in      (y_s[k]),
      .d_in      (d_s[k]),
      .ctrl_out  (ctrl_s[k+1]),
      .order_out (order_s[k+1]),
      .x_out     (x_s[k+1]),
      .y_out     (y_s[k+1]),
      .d_out     (d_s[k+1])
    );
  end

  // Output stage: drop the unused fields and strobe the result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_s[N].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_s[N].cmd == CMD_D_TO_XY) begin
      d_out <= '0;
      x_out <= COORD_W'(x_s[N]);
      y_out <= COORD_W'(y_s[N]);
    end else begin
      d_out <= DIST_W'(d_s[N]);
      x_out <= '0;
      y_out <= '0;
    end
  end

endmodule
